>>> hw/rtl/sls_pkg.sv
// ----------------------------------------------------------------------------
// sls_pkg : shared types and codes of the searchable LIFO stack
// Command, status and cell operation codes, and the transfer structs.
// ----------------------------------------------------------------------------
package sls_pkg;

   localparam int ENTRY_INDEX_W = 3;
   localparam int FILL_COUNT_W  = 4;
   localparam int MAX_RESULTS   = 8;

   localparam logic [2:0] CMD_PUSH    = 3'd0;
   localparam logic [2:0] CMD_POP     = 3'd1;
   localparam logic [2:0] CMD_CLEAR   = 3'd2;
   localparam logic [2:0] CMD_SEARCH  = 3'd3;
   localparam logic [2:0] CMD_REPLACE = 3'd4;
   localparam logic [2:0] CMD_DELETE  = 3'd5;
   localparam logic [2:0] CMD_LIST    = 3'd6;
   localparam logic [2:0] CMD_NOP     = 3'd7;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   localparam logic [2:0] CELL_HOLD     = 3'd0;
   localparam logic [2:0] CELL_PUSH     = 3'd1;
   localparam logic [2:0] CELL_ROT_DOWN = 3'd2;
   localparam logic [2:0] CELL_SHIFT_UP = 3'd3;
   localparam logic [2:0] CELL_REPLACE  = 3'd4;
   localparam logic [2:0] CELL_DELETE   = 3'd5;

   typedef struct packed {
      logic [2:0]          command;
      logic signed [31:0]  operand_value;
      logic signed [31:0]  replacement_value;
   } req_type;

   typedef struct packed {
      logic [1:0]                 status;
      logic signed [31:0]         result_value;
      logic [ENTRY_INDEX_W-1:0]   entry_index;
      logic [FILL_COUNT_W-1:0]    fill_count;
      logic                       last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]          op;
      logic signed [31:0]  operand;
      logic signed [31:0]  replacement;
   } cell_ctrl_type;

endpackage

>>> hw/rtl/sls_cell.sv
// ----------------------------------------------------------------------------
// sls_cell : one stack slot of the cell chain
// Holds one word, compares it with the operand, and replaces it, takes the
// top word or moves it to or from its neighbours as the controller commands.
// ----------------------------------------------------------------------------
module sls_cell
   import sls_pkg::*;
(
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic                active,
   input  logic                inject,
   input  logic signed [31:0]  prev_value,
   input  logic signed [31:0]  next_value,
   input  logic signed [31:0]  top_value,
   output logic signed [31:0]  entry,
   output logic                match
);

   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;

   assign match = (entry_ff == ctrl.operand);
   assign entry = entry_ff;

   always_comb begin
      case (ctrl.op) inside
         CELL_PUSH, CELL_ROT_DOWN: entry_in = prev_value;
         CELL_SHIFT_UP:            entry_in = next_value;
         CELL_REPLACE:             entry_in = (active && match) ? ctrl.replacement : entry_ff;
         CELL_DELETE:              entry_in = inject ? top_value : next_value;
         default:                  entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> hw/rtl/sls_ctrl.sv
// ----------------------------------------------------------------------------
// sls_ctrl : command sequencer of the searchable LIFO stack
// Takes one command at a time, steers the cell chain through its walks and
// drives the result register.
// ----------------------------------------------------------------------------
module sls_ctrl
   import sls_pkg::*;
#(
   parameter int STACK_DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_payload,
   output cell_ctrl_type            cell_ctrl,
   output logic [STACK_DEPTH-1:0]   cell_active,
   output logic [STACK_DEPTH-1:0]   cell_inject,
   input  logic [STACK_DEPTH-1:0]   cell_match,
   input  logic signed [31:0]       top_value
);

   localparam int CW       = $clog2(STACK_DEPTH + 1);
   localparam int IW       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LIST_CAP = (STACK_DEPTH < MAX_RESULTS) ? STACK_DEPTH : MAX_RESULTS;

   localparam logic [CW-1:0] DEPTH_C    = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] LAST_STEP  = CW'(STACK_DEPTH - 1);
   localparam logic [CW-1:0] CAP_C      = CW'(LIST_CAP);
   localparam logic [CW-1:0] CAP_LAST   = CW'(LIST_CAP - 1);
   localparam logic [CW-1:0] ONE_C      = CW'(1);
   localparam logic [CW:0]   DEPTH_WIDE = (CW + 1)'(STACK_DEPTH);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RUN    = 3'd1;
   localparam logic [2:0] ST_SEARCH = 3'd2;
   localparam logic [2:0] ST_LIST   = 3'd3;
   localparam logic [2:0] ST_DELETE = 3'd4;
   localparam logic [2:0] ST_TAIL   = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [2:0]          cmd_ff, cmd_in;
   logic signed [31:0]  operand_ff, operand_in;
   logic signed [31:0]  repl_ff, repl_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic [CW-1:0]       step_ff, step_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                held_valid_ff, held_valid_in;
   logic [CW-1:0]       held_index_ff, held_index_in;
   logic                hit_ff, hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                can_emit;
   logic                emit;
   rsp_type             emit_data;
   logic [CW-1:0]       walk_index;
   logic                ptr_match;
   logic                replace_hit;
   logic [CW:0]         obs_sum;
   logic                obs_hit;
   logic [CW-1:0]       obs_index;

   function automatic rsp_type make_rsp(logic [1:0] status, logic signed [31:0] value,
                                        logic [CW-1:0] index, logic [CW-1:0] fill,
                                        logic last);
      rsp_type r;
      r.status       = status;
      r.result_value = value;
      r.entry_index  = ENTRY_INDEX_W'(index);
      r.fill_count   = FILL_COUNT_W'(fill);
      r.last         = last;
      return r;
   endfunction

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign can_emit    = !rsp_valid_ff || !rsp_stall;

   // slot under the delete walk, and the slot shown in the list walk
   assign walk_index  = fill_ff - step_ff - ONE_C;
   assign ptr_match   = cell_match[walk_index[IW-1:0]];

   always_comb begin
      for (int k = 0; k < STACK_DEPTH; k++) begin
         cell_active[k] = (CW'(k) < fill_ff);
         cell_inject[k] = (walk_index == CW'(k + 1));
      end
   end

   assign replace_hit = |(cell_match & cell_active);

   // search watches the far cell while the ring turns towards it
   assign obs_sum   = {1'b0, step_ff} + {1'b0, fill_ff};
   assign obs_hit   = (obs_sum >= DEPTH_WIDE) && cell_match[STACK_DEPTH-1];
   assign obs_index = CW'(obs_sum - DEPTH_WIDE);

   always_comb begin
      state_in              = state_ff;
      cmd_in                = cmd_ff;
      operand_in            = operand_ff;
      repl_in               = repl_ff;
      fill_in               = fill_ff;
      step_in               = step_ff;
      count_in              = count_ff;
      held_valid_in         = held_valid_ff;
      held_index_in         = held_index_ff;
      hit_in                = hit_ff;
      cell_ctrl.op          = CELL_HOLD;
      cell_ctrl.operand     = operand_ff;
      cell_ctrl.replacement = repl_ff;
      emit                  = 1'b0;
      emit_data             = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_payload.command;
               operand_in = req_payload.operand_value;
               repl_in    = req_payload.replacement_value;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            if (can_emit) begin
               state_in = ST_IDLE;
               if (cmd_ff == CMD_PUSH) begin
                  emit = 1'b1;
                  if (fill_ff == DEPTH_C) begin
                     emit_data = make_rsp(STATUS_FULL, '0, '0, fill_ff, 1'b1);
                  end else begin
                     cell_ctrl.op = CELL_PUSH;
                     emit_data    = make_rsp(STATUS_OK, operand_ff, fill_ff,
                                             fill_ff + ONE_C, 1'b1);
                     fill_in      = fill_ff + ONE_C;
                  end
               end else if (cmd_ff == CMD_NOP) begin
                  emit = 1'b0;
               end else if (fill_ff == '0) begin
                  emit      = 1'b1;
                  emit_data = make_rsp(STATUS_EMPTY, '0, '0, '0, 1'b1);
               end else begin
                  unique case (cmd_ff)
                     CMD_POP: begin
                        cell_ctrl.op = CELL_SHIFT_UP;
                        emit         = 1'b1;
                        emit_data    = make_rsp(STATUS_OK, top_value, fill_ff - ONE_C,
                                                fill_ff - ONE_C, 1'b1);
                        fill_in      = fill_ff - ONE_C;
                     end
                     CMD_CLEAR: begin
                        emit      = 1'b1;
                        emit_data = make_rsp(STATUS_OK, '0, '0, '0, 1'b1);
                        fill_in   = '0;
                     end
                     CMD_REPLACE: begin
                        cell_ctrl.op = CELL_REPLACE;
                        emit         = 1'b1;
                        emit_data    = replace_hit ?
                                       make_rsp(STATUS_OK, repl_ff, '0, fill_ff, 1'b1) :
                                       make_rsp(STATUS_NOT_FOUND, '0, '0, fill_ff, 1'b1);
                     end
                     CMD_SEARCH: begin
                        step_in       = '0;
                        count_in      = '0;
                        held_valid_in = 1'b0;
                        state_in      = ST_SEARCH;
                     end
                     CMD_LIST: begin
                        step_in  = '0;
                        state_in = ST_LIST;
                     end
                     CMD_DELETE: begin
                        step_in  = '0;
                        hit_in   = 1'b0;
                        state_in = ST_DELETE;
                     end
                     default: begin
                        state_in = ST_IDLE;
                     end
                  endcase
               end
            end
         end
         ST_SEARCH: begin
            if (can_emit) begin
               cell_ctrl.op = CELL_ROT_DOWN;
               if (obs_hit && (count_ff < CAP_C)) begin
                  if (held_valid_ff) begin
                     emit      = 1'b1;
                     emit_data = make_rsp(STATUS_OK, operand_ff, held_index_ff,
                                          fill_ff, 1'b0);
                  end
                  held_valid_in = 1'b1;
                  held_index_in = obs_index;
                  count_in      = count_ff + ONE_C;
               end
               if (step_ff == LAST_STEP) begin
                  state_in = ST_TAIL;
               end else begin
                  step_in = step_ff + ONE_C;
               end
            end
         end
         ST_LIST: begin
            if (can_emit) begin
               cell_ctrl.op = CELL_SHIFT_UP;
               if ((step_ff < fill_ff) && (step_ff < CAP_C)) begin
                  emit      = 1'b1;
                  emit_data = make_rsp(STATUS_OK, top_value, walk_index, fill_ff,
                                       (step_ff == fill_ff - ONE_C) ||
                                       (step_ff == CAP_LAST));
               end
               if (step_ff == LAST_STEP) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + ONE_C;
               end
            end
         end
         ST_DELETE: begin
            if (step_ff < fill_ff) begin
               if (ptr_match) begin
                  cell_ctrl.op = CELL_DELETE;
                  fill_in      = fill_ff - ONE_C;
                  hit_in       = 1'b1;
               end
               step_in = step_ff + ONE_C;
            end else begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            if (can_emit) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               if (cmd_ff == CMD_SEARCH) begin
                  emit_data = held_valid_ff ?
                              make_rsp(STATUS_OK, operand_ff, held_index_ff, fill_ff, 1'b1) :
                              make_rsp(STATUS_NOT_FOUND, '0, '0, fill_ff, 1'b1);
               end else begin
                  emit_data = hit_ff ?
                              make_rsp(STATUS_OK, operand_ff, '0, fill_ff, 1'b1) :
                              make_rsp(STATUS_NOT_FOUND, '0, '0, fill_ff, 1'b1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
      rsp_in       = emit ? emit_data : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      operand_ff    <= operand_in;
      repl_ff       <= repl_in;
      step_ff       <= step_in;
      count_ff      <= count_in;
      held_index_ff <= held_index_in;
      hit_ff        <= hit_in;
      rsp_ff        <= rsp_in;
   end

endmodule

>>> hw/rtl/searchable_lifo_stack_unit.sv
// ----------------------------------------------------------------------------
// searchable_lifo_stack_unit : bounded LIFO stack with search, replace,
// delete and list commands
//
//   channel | ports          | direction | transfer
//   --------+----------------+-----------+-------------------------------
//   request | req_valid/stall| in        | one command with its operands
//   result  | rsp_valid/stall| out       | up to eight results a command
//
// Push, pop, clear and replace take the transfer and one step. Search and
// list turn the cell ring once round, one slot a cycle unless stalled, and
// delete walks the filled slots before it sends its result. Reset clears
// the fill count, the state and the result valid; slot contents stay until
// pushed. rsp_stall freezes the search and list walks while the result
// register is held; the delete walk runs on and waits only to send its
// result.
// ----------------------------------------------------------------------------
module searchable_lifo_stack_unit
   import sls_pkg::*;
#(
   parameter int STACK_DEPTH = 8
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_payload,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_payload
);

   cell_ctrl_type             cell_ctrl;
   logic [STACK_DEPTH-1:0]    cell_active;
   logic [STACK_DEPTH-1:0]    cell_inject;
   logic [STACK_DEPTH-1:0]    cell_match;
   logic signed [31:0]        entry      [STACK_DEPTH];
   logic signed [31:0]        prev_value [STACK_DEPTH];
   logic signed [31:0]        next_value [STACK_DEPTH];

   sls_ctrl #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cell_ctrl   (cell_ctrl),
      .cell_active (cell_active),
      .cell_inject (cell_inject),
      .cell_match  (cell_match),
      .top_value   (entry[0])
   );

   // cell 0 is the top; the chain wraps round for the walks
   for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign prev_value[k] = (cell_ctrl.op == CELL_PUSH) ? cell_ctrl.operand
                                                            : entry[STACK_DEPTH-1];
      end else begin : g_body
         assign prev_value[k] = entry[k-1];
      end
      if (k == STACK_DEPTH - 1) begin : g_tail
         assign next_value[k] = entry[0];
      end else begin : g_link
         assign next_value[k] = entry[k+1];
      end

      sls_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .active     (cell_active[k]),
         .inject     (cell_inject[k]),
         .prev_value (prev_value[k]),
         .next_value (next_value[k]),
         .top_value  (entry[0]),
         .entry      (entry[k]),
         .match      (cell_match[k])
      );
   end

endmodule

>>> hw/rtl/sls_checker.sv
// ----------------------------------------------------------------------------
// sls_checker : port-level checks of the searchable LIFO stack
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module sls_checker
   import sls_pkg::*;
#(
   parameter int STACK_DEPTH = 8
) (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_stall,
   input logic     rsp_valid,
   input logic     rsp_stall,
   input rsp_type  rsp_payload
);

   // one command at a time: a transfer closes the request side
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a command was in progress");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == STATUS_FULL) |->
         (rsp_payload.fill_count == FILL_COUNT_W'(STACK_DEPTH)) &&
         (rsp_payload.result_value == 0) && rsp_payload.last)
      else $error("full result with wrong count, value or last");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == STATUS_EMPTY) |->
         (rsp_payload.fill_count == 0) && rsp_payload.last)
      else $error("empty result with nonzero count or without last");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (STACK_DEPTH > 15) ||
         (rsp_payload.fill_count <= FILL_COUNT_W'(STACK_DEPTH)))
      else $error("fill count beyond the stack depth");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

endmodule

bind searchable_lifo_stack_unit sls_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_sls_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
